FILE: rtl/core/pixel_to_geo_homography_map_core_macros.svh
// Assertion macros shared by the pixel-to-geo map RTL.
// Users must have clk and arst_n in scope; no other dependencies.
`ifndef PIXEL_TO_GEO_HOMOGRAPHY_MAP_CORE_MACROS_SVH
`define PIXEL_TO_GEO_HOMOGRAPHY_MAP_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define P2G_ASSERT_IMPL(label, en, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (en) |-> (cond)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define P2G_ASSERT_NEXT(label, en, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (en) |=> (cond)) \
		else $error(msg);

`endif

FILE: rtl/core/p2g_pkg.sv
// Shared types, constants and width helpers for the pixel-to-geo map core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package p2g_pkg;

	localparam int PIXEL_BITS_DEF     = 13;
	localparam int COEF_FRAC_BITS_DEF = 32;
	localparam int PERSP_FRAC         = 31;
	localparam int QUOT_BITS          = 32;
	localparam int FIFO_DEPTH         = 4;
	localparam int ADDR_W             = 6;
	localparam int DATA_W             = 64;

	typedef enum logic [2:0] {
		REG_LAT_GAIN_X = 3'd0,
		REG_LAT_GAIN_Y = 3'd1,
		REG_LAT_BIAS   = 3'd2,
		REG_LON_GAIN_X = 3'd3,
		REG_LON_GAIN_Y = 3'd4,
		REG_LON_BIAS   = 3'd5,
		REG_PERSP_PAIR = 3'd6,
		REG_OFFSET_PAIR = 3'd7
	} p2g_reg_t;

	typedef struct packed {
		logic [63:0] lat_gain_x;
		logic [63:0] lat_gain_y;
		logic [63:0] lat_bias;
		logic [63:0] lon_gain_x;
		logic [63:0] lon_gain_y;
		logic [63:0] lon_bias;
		logic [63:0] perspective_pair;
		logic [63:0] offset_pair;
	} p2g_cfg_t;

	// Signed width of the divisor w and of the two numerators.
	function automatic int p2g_w_w(input int pb);
		return pb + 34;
	endfunction

	function automatic int p2g_num_w(input int pb);
		return pb + 66;
	endfunction

	// Left shift of the numerator magnitude and of w that align the rounded quotient.
	function automatic int p2g_lsh(input int f);
		return (f < PERSP_FRAC + 1) ? (PERSP_FRAC + 1 - f) : 0;
	endfunction

	function automatic int p2g_rsh(input int f);
		return (f > PERSP_FRAC + 1) ? (f - PERSP_FRAC - 1) : 0;
	endfunction

	// Width of the scaled divisor 2w.
	function automatic int p2g_d_w(input int pb, input int f);
		return p2g_w_w(pb) + p2g_rsh(f) + 1;
	endfunction

	// Width of the dividend and of the partial remainders.
	function automatic int p2g_r_w(input int pb, input int f);
		int a;
		int b;
		a = p2g_num_w(pb) + p2g_lsh(f) + 1;
		b = p2g_d_w(pb, f) + QUOT_BITS + 1;
		return (a > b) ? a : b;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/p2g_regs.sv
// Configuration register file with an APB-style write/read port.
// Depends on p2g_pkg.
`timescale 1ns / 1ps
`default_nettype none
module p2g_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [p2g_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [p2g_pkg::DATA_W-1:0]    pwdata,
	output logic      [p2g_pkg::DATA_W-1:0]    prdata,
	output logic                               pready,
	output p2g_pkg::p2g_cfg_t                  cfg
);

	p2g_pkg::p2g_cfg_t cfg_q;
	p2g_pkg::p2g_reg_t sel;

	assign sel    = p2g_pkg::p2g_reg_t'(paddr[p2g_pkg::ADDR_W-1:3]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (sel)
				p2g_pkg::REG_LAT_GAIN_X:  cfg_q.lat_gain_x       <= pwdata;
				p2g_pkg::REG_LAT_GAIN_Y:  cfg_q.lat_gain_y       <= pwdata;
				p2g_pkg::REG_LAT_BIAS:    cfg_q.lat_bias         <= pwdata;
				p2g_pkg::REG_LON_GAIN_X:  cfg_q.lon_gain_x       <= pwdata;
				p2g_pkg::REG_LON_GAIN_Y:  cfg_q.lon_gain_y       <= pwdata;
				p2g_pkg::REG_LON_BIAS:    cfg_q.lon_bias         <= pwdata;
				p2g_pkg::REG_PERSP_PAIR:  cfg_q.perspective_pair <= pwdata;
				p2g_pkg::REG_OFFSET_PAIR: cfg_q.offset_pair      <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			p2g_pkg::REG_LAT_GAIN_X:  prdata = cfg_q.lat_gain_x;
			p2g_pkg::REG_LAT_GAIN_Y:  prdata = cfg_q.lat_gain_y;
			p2g_pkg::REG_LAT_BIAS:    prdata = cfg_q.lat_bias;
			p2g_pkg::REG_LON_GAIN_X:  prdata = cfg_q.lon_gain_x;
			p2g_pkg::REG_LON_GAIN_Y:  prdata = cfg_q.lon_gain_y;
			p2g_pkg::REG_LON_BIAS:    prdata = cfg_q.lon_bias;
			p2g_pkg::REG_PERSP_PAIR:  prdata = cfg_q.perspective_pair;
			p2g_pkg::REG_OFFSET_PAIR: prdata = cfg_q.offset_pair;
			default:                  prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/core/p2g_front.sv
// Front pipeline: products, sums, divisor check and dividend/divisor forming.
// Depends on p2g_pkg.
`timescale 1ns / 1ps
`default_nettype none
module p2g_front #(
	parameter int PIXEL_BITS     = p2g_pkg::PIXEL_BITS_DEF,
	parameter int COEF_FRAC_BITS = p2g_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  p2g_pkg::p2g_cfg_t            cfg,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [PIXEL_BITS-1:0]   pixel_x,
	input  wire logic [PIXEL_BITS-1:0]   pixel_y,
	input  wire logic                    q_full,
	output logic                         push,
	output logic                         bad_s4,
	output logic                         neg_lat_s4,
	output logic                         neg_lon_s4,
	output logic [p2g_pkg::p2g_r_w(PIXEL_BITS, COEF_FRAC_BITS)-1:0] nd_lat_s4,
	output logic [p2g_pkg::p2g_r_w(PIXEL_BITS, COEF_FRAC_BITS)-1:0] nd_lon_s4,
	output logic [p2g_pkg::p2g_d_w(PIXEL_BITS, COEF_FRAC_BITS)-1:0] dv_s4
);

	localparam int PW   = PIXEL_BITS + 33;
	localparam int GW   = PIXEL_BITS + 65;
	localparam int WW   = p2g_pkg::p2g_w_w(PIXEL_BITS);
	localparam int NUMW = p2g_pkg::p2g_num_w(PIXEL_BITS);
	localparam int LSH  = p2g_pkg::p2g_lsh(COEF_FRAC_BITS);
	localparam int RSH  = p2g_pkg::p2g_rsh(COEF_FRAC_BITS);
	localparam int RW   = p2g_pkg::p2g_r_w(PIXEL_BITS, COEF_FRAC_BITS);
	localparam int DW   = p2g_pkg::p2g_d_w(PIXEL_BITS, COEF_FRAC_BITS);
	localparam logic signed [WW-1:0] W_ONE = WW'(1) << p2g_pkg::PERSP_FRAC;

	logic front_en;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [PIXEL_BITS-1:0] x_s1, y_s1;
	logic signed [PW-1:0] ppx_s2, ppy_s2;
	logic signed [GW-1:0] plx_s2, ply_s2, pnx_s2, pny_s2;
	logic signed [WW-1:0] w_s3;
	logic signed [NUMW-1:0] nlat_s3, nlon_s3;
	logic [NUMW-1:0] mag_lat, mag_lon;
	logic [WW-1:0] w_pos;

	// The whole front moves together; it halts only when its last word cannot enter the queue.
	assign front_en = !(v_s4 && q_full);
	assign in_stall = !front_en;
	assign push     = v_s4 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (front_en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		mag_lat = nlat_s3[NUMW-1] ? NUMW'(~nlat_s3 + 1'b1) : NUMW'(nlat_s3);
		mag_lon = nlon_s3[NUMW-1] ? NUMW'(~nlon_s3 + 1'b1) : NUMW'(nlon_s3);
		w_pos   = w_s3;
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			x_s1 <= pixel_x;
			y_s1 <= pixel_y;

			ppx_s2 <= PW'($signed(cfg.perspective_pair[63:32])) * PW'($signed({1'b0, x_s1}));
			ppy_s2 <= PW'($signed(cfg.perspective_pair[31:0])) * PW'($signed({1'b0, y_s1}));
			plx_s2 <= GW'($signed(cfg.lat_gain_x)) * GW'($signed({1'b0, x_s1}));
			ply_s2 <= GW'($signed(cfg.lat_gain_y)) * GW'($signed({1'b0, y_s1}));
			pnx_s2 <= GW'($signed(cfg.lon_gain_x)) * GW'($signed({1'b0, x_s1}));
			pny_s2 <= GW'($signed(cfg.lon_gain_y)) * GW'($signed({1'b0, y_s1}));

			w_s3    <= WW'(ppx_s2) + WW'(ppy_s2) + W_ONE;
			nlat_s3 <= NUMW'(plx_s2) + NUMW'(ply_s2) + NUMW'($signed(cfg.lat_bias));
			nlon_s3 <= NUMW'(pnx_s2) + NUMW'(pny_s2) + NUMW'($signed(cfg.lon_bias));

			// Rounded quotient is floor((mag*2^LSH + w*2^RSH) / (w*2^(RSH+1))).
			bad_s4     <= w_s3[WW-1] || (w_s3 == '0);
			neg_lat_s4 <= nlat_s3[NUMW-1];
			neg_lon_s4 <= nlon_s3[NUMW-1];
			nd_lat_s4  <= (RW'(mag_lat) << LSH) + (RW'(w_pos) << RSH);
			nd_lon_s4  <= (RW'(mag_lon) << LSH) + (RW'(w_pos) << RSH);
			dv_s4      <= DW'(w_pos) << (RSH + 1);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/p2g_fifo.sv
// Small synchronous queue that decouples the front and back pipelines.
// Depends on p2g_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none
module p2g_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  not_empty
);

	localparam int DEPTH = p2g_pkg::FIFO_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign dout      = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/p2g_back.sv
// Back pipeline: range check, 32-stage restoring divider, offset and saturation.
// Depends on p2g_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_to_geo_homography_map_core_macros.svh"
module p2g_back #(
	parameter int PIXEL_BITS     = p2g_pkg::PIXEL_BITS_DEF,
	parameter int COEF_FRAC_BITS = p2g_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  p2g_pkg::p2g_cfg_t            cfg,
	input  wire logic                    head_valid,
	output logic                         pop,
	input  wire logic                    bad_in,
	input  wire logic                    neg_lat_in,
	input  wire logic                    neg_lon_in,
	input  wire logic [p2g_pkg::p2g_r_w(PIXEL_BITS, COEF_FRAC_BITS)-1:0] nd_lat_in,
	input  wire logic [p2g_pkg::p2g_r_w(PIXEL_BITS, COEF_FRAC_BITS)-1:0] nd_lon_in,
	input  wire logic [p2g_pkg::p2g_d_w(PIXEL_BITS, COEF_FRAC_BITS)-1:0] dv_in,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [p2g_pkg::QUOT_BITS-1:0] lat_scaled,
	output logic [p2g_pkg::QUOT_BITS-1:0] lon_scaled,
	output logic                         bad_divisor,
	output logic                         clipped
);

	localparam int RW = p2g_pkg::p2g_r_w(PIXEL_BITS, COEF_FRAC_BITS);
	localparam int DW = p2g_pkg::p2g_d_w(PIXEL_BITS, COEF_FRAC_BITS);
	localparam int QB = p2g_pkg::QUOT_BITS;

	// Returns {clip, value} for one coordinate.
	function automatic logic [QB:0] finish_row(input logic ovf, input logic neg,
			input logic [QB-1:0] q, input logic [QB-1:0] off);
		logic [QB:0] sum;
		sum = {1'b0, off} + {1'b0, q};
		if (ovf) begin
			return {1'b1, neg ? {QB{1'b0}} : {QB{1'b1}}};
		end else if (neg) begin
			return (q > off) ? {1'b1, {QB{1'b0}}} : {1'b0, off - q};
		end else begin
			return sum[QB] ? {1'b1, {QB{1'b1}}} : {1'b0, sum[QB-1:0]};
		end
	endfunction

	logic back_en;
	logic v_s1;
	logic bad_s1, nlat_s1, nlon_s1;
	logic [RW-1:0] ndl_s1, ndn_s1;
	logic [DW-1:0] dv_s1;

	logic          v_sk    [QB+1];
	logic          bad_sk  [QB+1];
	logic          nlat_sk [QB+1];
	logic          nlon_sk [QB+1];
	logic          ovfl_sk [QB+1];
	logic          ovfn_sk [QB+1];
	logic [RW-1:0] reml_sk [QB+1];
	logic [RW-1:0] remn_sk [QB+1];
	logic [DW-1:0] dv_sk   [QB+1];
	logic [QB-1:0] ql_sk   [QB+1];
	logic [QB-1:0] qn_sk   [QB+1];

	logic          out_valid_q;
	logic [QB-1:0] lat_q, lon_q;
	logic          bad_q, clip_q;
	logic [QB:0]   fin_lat, fin_lon;

	assign back_en = !(out_valid_q && out_stall);
	assign pop     = back_en && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_sk[0]    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (back_en) begin
			v_s1       <= head_valid;
			v_sk[0]    <= v_s1;
			out_valid_q <= v_sk[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (back_en) begin
			bad_s1  <= bad_in;
			nlat_s1 <= neg_lat_in;
			nlon_s1 <= neg_lon_in;
			ndl_s1  <= nd_lat_in;
			ndn_s1  <= nd_lon_in;
			dv_s1   <= dv_in;

			// A rounded quotient at or above 2^32 saturates.
			bad_sk[0]  <= bad_s1;
			nlat_sk[0] <= nlat_s1;
			nlon_sk[0] <= nlon_s1;
			ovfl_sk[0] <= ndl_s1 >= (RW'(dv_s1) << QB);
			ovfn_sk[0] <= ndn_s1 >= (RW'(dv_s1) << QB);
			reml_sk[0] <= ndl_s1;
			remn_sk[0] <= ndn_s1;
			dv_sk[0]   <= dv_s1;
			ql_sk[0]   <= '0;
			qn_sk[0]   <= '0;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [RW:0] trial_l, trial_n;

		assign trial_l = {1'b0, reml_sk[k]} - {1'b0, RW'(dv_sk[k]) << (QB - 1 - k)};
		assign trial_n = {1'b0, remn_sk[k]} - {1'b0, RW'(dv_sk[k]) << (QB - 1 - k)};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k+1] <= 1'b0;
			end else if (back_en) begin
				v_sk[k+1] <= v_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (back_en) begin
				bad_sk[k+1]  <= bad_sk[k];
				nlat_sk[k+1] <= nlat_sk[k];
				nlon_sk[k+1] <= nlon_sk[k];
				ovfl_sk[k+1] <= ovfl_sk[k];
				ovfn_sk[k+1] <= ovfn_sk[k];
				dv_sk[k+1]   <= dv_sk[k];
				reml_sk[k+1] <= trial_l[RW] ? reml_sk[k] : trial_l[RW-1:0];
				remn_sk[k+1] <= trial_n[RW] ? remn_sk[k] : trial_n[RW-1:0];
				ql_sk[k+1]   <= {ql_sk[k][QB-2:0], !trial_l[RW]};
				qn_sk[k+1]   <= {qn_sk[k][QB-2:0], !trial_n[RW]};
			end
		end
	end

	always_comb begin
		fin_lat = finish_row(ovfl_sk[QB], nlat_sk[QB], ql_sk[QB], cfg.offset_pair[63:32]);
		fin_lon = finish_row(ovfn_sk[QB], nlon_sk[QB], qn_sk[QB], cfg.offset_pair[31:0]);
	end

	always_ff @(posedge clk) begin
		if (back_en && v_sk[QB]) begin
			bad_q  <= bad_sk[QB];
			lat_q  <= bad_sk[QB] ? '0 : fin_lat[QB-1:0];
			lon_q  <= bad_sk[QB] ? '0 : fin_lon[QB-1:0];
			clip_q <= !bad_sk[QB] && (fin_lat[QB] || fin_lon[QB]);
		end
	end

	assign out_valid   = out_valid_q;
	assign lat_scaled  = lat_q;
	assign lon_scaled  = lon_q;
	assign bad_divisor = bad_q;
	assign clipped     = clip_q;

	`P2G_ASSERT_IMPL(a_bad_zero, out_valid_q && bad_q, (lat_q == '0) && (lon_q == '0) && !clip_q, "bad divisor result not zeroed")
	`P2G_ASSERT_IMPL(a_clip_rail, out_valid_q && clip_q, (lat_q == '0) || (lat_q == '1) || (lon_q == '0) || (lon_q == '1), "clipped result not at a rail")
	`P2G_ASSERT_IMPL(a_out_source, $rose(out_valid_q), $past(v_sk[QB]), "result word appeared without a divider word")
	`P2G_ASSERT_NEXT(a_out_drain, out_valid_q && !out_stall && !v_sk[QB], !out_valid_q, "result word repeated")

endmodule
`default_nettype wire

FILE: rtl/core/pixel_to_geo_homography_map_core.sv
// Top level of the pixel-to-geo homography map core.
// Depends on p2g_pkg, p2g_regs, p2g_front, p2g_fifo and p2g_back.
`timescale 1ns / 1ps
`default_nettype none
// Maps one pixel (pixel_x, pixel_y) to scaled latitude and longitude through a
// 3x3 homography whose last coefficient is one. The core takes one word per clock
// and gives one result word per clock for as long as neither side stalls. A word
// accepted at the input passes four front stages (input, products, sums, dividend
// forming), the queue storage, the back input register, one range-check stage, 32
// restoring-divider stages that each produce one quotient bit per row, and the
// output register. The divider stages are fully pipelined, so the rate stays one
// word per cycle while neither side stalls. A stalled output freezes the back part,
// and the four-entry queue lets the front keep accepting words until it is full.
// The rounded quotient is computed exactly, half away from zero, then the unsigned
// offset is added and the sum saturates to 0..2^32-1 with clipped set. A divisor
// w that is zero or negative gives zero coordinates with bad_divisor set.
// Coefficients are written over the APB port as 64-bit registers at byte address
// 8*i in this order: lat_gain_x, lat_gain_y, lat_bias, lon_gain_x, lon_gain_y,
// lon_bias, perspective_pair, offset_pair. Write them only while the core is idle.
module pixel_to_geo_homography_map_core #(
	parameter int PIXEL_BITS     = p2g_pkg::PIXEL_BITS_DEF,
	parameter int COEF_FRAC_BITS = p2g_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [PIXEL_BITS-1:0]         pixel_x,
	input  wire logic [PIXEL_BITS-1:0]         pixel_y,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [p2g_pkg::QUOT_BITS-1:0]      lat_scaled,
	output logic [p2g_pkg::QUOT_BITS-1:0]      lon_scaled,
	output logic                               bad_divisor,
	output logic                               clipped,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [p2g_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [p2g_pkg::DATA_W-1:0]    pwdata,
	output logic      [p2g_pkg::DATA_W-1:0]    prdata,
	output logic                               pready
);

	localparam int RW = p2g_pkg::p2g_r_w(PIXEL_BITS, COEF_FRAC_BITS);
	localparam int DW = p2g_pkg::p2g_d_w(PIXEL_BITS, COEF_FRAC_BITS);
	localparam int FW = 2 * RW + DW + 3;

	p2g_pkg::p2g_cfg_t cfg;

	logic          push, q_full, q_pop, q_not_empty;
	logic          f_bad, f_nlat, f_nlon;
	logic [RW-1:0] f_ndl, f_ndn;
	logic [DW-1:0] f_dv;
	logic [FW-1:0] q_din, q_dout;

	p2g_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The front computes w and both numerators and flags a bad divisor.
	p2g_front #(
		.PIXEL_BITS     (PIXEL_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.q_full     (q_full),
		.push       (push),
		.bad_s4     (f_bad),
		.neg_lat_s4 (f_nlat),
		.neg_lon_s4 (f_nlon),
		.nd_lat_s4  (f_ndl),
		.nd_lon_s4  (f_ndn),
		.dv_s4      (f_dv)
	);

	assign q_din = {f_bad, f_nlat, f_nlon, f_ndl, f_ndn, f_dv};

	// The queue lets the front keep accepting words while the output is stalled.
	p2g_fifo #(
		.WIDTH (FW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (q_din),
		.full      (q_full),
		.pop       (q_pop),
		.dout      (q_dout),
		.not_empty (q_not_empty)
	);

	p2g_back #(
		.PIXEL_BITS     (PIXEL_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.head_valid  (q_not_empty),
		.pop         (q_pop),
		.bad_in      (q_dout[FW-1]),
		.neg_lat_in  (q_dout[FW-2]),
		.neg_lon_in  (q_dout[FW-3]),
		.nd_lat_in   (q_dout[2*RW+DW-1:RW+DW]),
		.nd_lon_in   (q_dout[RW+DW-1:DW]),
		.dv_in       (q_dout[DW-1:0]),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.lat_scaled  (lat_scaled),
		.lon_scaled  (lon_scaled),
		.bad_divisor (bad_divisor),
		.clipped     (clipped)
	);

endmodule
`default_nettype wire
